@@ rtl/gsf_pkg.sv @@
`timescale 1ns / 1ps

package gsf_pkg;

  // Default configuration of the filter
  localparam int MAX_TAPS         = 7;
  localparam int SAMPLE_BITS      = 16;
  localparam int WEIGHT_FRAC_BITS = 15;

  // Register file layout
  localparam int WEIGHT_BITS  = 16;
  localparam int WEIGHT_REGS  = 7;
  localparam int TAPS_BITS    = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = WEIGHT_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TAPS_USED    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_WEIGHT_0 = 3'd1;

  localparam logic [TAPS_BITS-1:0]   TAPS_RESET = 3'd1;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 16'd32768;

  // Control that travels alongside the data of one transaction
  typedef struct packed {
    logic vld;
    logic last;
  } gsf_ctl_t;

endpackage

@@ rtl/gaussian_smoothing_fir_zero_pad.sv @@
// Streaming 1-D smoothing filter with zero padding at both row ends.
// Input channel in_*: one height sample per transaction, in_row_end on the
// last sample of a row. Output channel out_*: one smoothed height per
// transaction, out_last_of_row on the result for the row's last position.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. Configuration (tap count, seven unsigned Q1.15 weights) is
// written through cfg_we/cfg_index/cfg_wdata; the user must write it only
// while the block is idle, and the block does not enforce this. Throughput:
// one sample per cycle while in_stall is low. A row end starts a flush,
// during which the input is stalled and zeros are shifted through the cells.
// Results lag the stream by taps_used/2 samples; an accepted sample passes
// through the window cells, the product registers, the adder tree levels
// and the output register.
// Stalling the output fills the output register and then a one-entry skid
// register; in_stall rises once the skid is full and also during a flush.
// Reset (synchronous, rst_n low) clears the window, the row counter, the
// pipeline and output valid flags and restores taps_used = 1 with
// tap_weight_0 = one and all other weights zero.
`timescale 1ns / 1ps

module gaussian_smoothing_fir_zero_pad #(
  parameter int MAX_TAPS         = gsf_pkg::MAX_TAPS,
  parameter int SAMPLE_BITS      = gsf_pkg::SAMPLE_BITS,
  parameter int WEIGHT_FRAC_BITS = gsf_pkg::WEIGHT_FRAC_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [gsf_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [gsf_pkg::CFG_DATA_BITS-1:0]        cfg_wdata,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [SAMPLE_BITS-1:0]            in_height_sample,
  input  logic                                     in_row_end,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [SAMPLE_BITS-1:0]            out_smoothed_height,
  output logic                                     out_last_of_row
);

  localparam int WB     = gsf_pkg::WEIGHT_BITS;
  localparam int PROD_W = SAMPLE_BITS + WB;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int SEEN_W = $clog2(MAX_TAPS + 1);
  localparam int HLIM_T = (MAX_TAPS - 1) / 2;
  localparam int HLIM_W = (gsf_pkg::WEIGHT_REGS - 1) / 2;
  localparam int HMAX   = (HLIM_T < HLIM_W) ? HLIM_T : HLIM_W;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (WEIGHT_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic {ST_STREAM, ST_FLUSH} state_t;

  // Configuration registers
  logic [gsf_pkg::TAPS_BITS-1:0] taps_r;
  logic [WB-1:0]                 wt_r [gsf_pkg::WEIGHT_REGS];

  // Sequencer
  state_t            state_r;
  logic [SEEN_W-1:0] seen_r;
  logic [SEEN_W-1:0] n_r;
  logic [SEEN_W-1:0] n_cur;
  logic [1:0]        fd_r;
  logic [1:0]        half_w;
  logic              clear_pend_r;
  logic              adv;
  logic              in_acc;
  logic              op_go;
  logic              op_emit;
  logic              op_last;
  logic signed [SAMPLE_BITS-1:0] op_x;

  // Cells and pipeline
  logic signed [SAMPLE_BITS-1:0] tap     [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] tap_in  [MAX_TAPS];
  logic        [WB-1:0]          coeff   [MAX_TAPS];
  logic signed [PROD_W-1:0]      prod    [MAX_TAPS];
  gsf_pkg::gsf_ctl_t             a_r;
  gsf_pkg::gsf_ctl_t             b_r;
  gsf_pkg::gsf_ctl_t             t_ctl;
  logic signed [ACC_W-1:0]       t_sum;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [SAMPLE_BITS-1:0] res;

  // Output register and skid
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;
  logic                          out_last_r;
  logic                          skid_vld_r;
  logic signed [SAMPLE_BITS-1:0] skid_data_r;
  logic                          skid_last_r;
  logic                          take;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= gsf_pkg::TAPS_RESET;
      wt_r[0] <= gsf_pkg::WEIGHT_ONE;
      for (int i = 1; i < gsf_pkg::WEIGHT_REGS; i++) begin
        wt_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == gsf_pkg::CFG_TAPS_USED) begin
        taps_r <= cfg_wdata[gsf_pkg::TAPS_BITS-1:0];
      end else if (cfg_index >= gsf_pkg::CFG_TAP_WEIGHT_0) begin
        wt_r[cfg_index - gsf_pkg::CFG_TAP_WEIGHT_0] <= cfg_wdata[WB-1:0];
      end
    end
  end

  // Half width of the kernel; an even tap count acts as the next odd one
  assign half_w = (int'(taps_r[2:1]) > HMAX) ? 2'(HMAX) : taps_r[2:1];

  // Align weights to window cells: cell k sees weight 2h-k
  always_comb begin
    logic [2:0] sel;
    sel = '0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      sel = 3'(2 * int'(half_w) - k);
      coeff[k] = (k <= 2 * int'(half_w)) ? wt_r[sel] : '0;
    end
  end

  // Advance the pipeline while the skid register is free
  assign adv      = !skid_vld_r;
  assign in_stall = !adv || (state_r == ST_FLUSH);
  assign in_acc   = in_valid && !in_stall;

  assign n_cur = (seen_r == SEEN_W'(MAX_TAPS)) ? seen_r : seen_r + 1'b1;

  // Pick the window operation: a real sample or a flush zero
  always_comb begin
    if (state_r == ST_FLUSH) begin
      op_go   = adv;
      op_x    = '0;
      op_emit = 32'(fd_r) < 32'(n_r);
      op_last = (fd_r == 2'd0);
    end else begin
      op_go   = in_acc;
      op_x    = in_height_sample;
      op_emit = 32'(n_cur) > 32'(half_w);
      op_last = in_row_end && (half_w == 2'd0);
    end
  end

  // Track row position and flush progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_STREAM;
      seen_r       <= '0;
      n_r          <= '0;
      fd_r         <= '0;
      clear_pend_r <= 1'b0;
    end else begin
      if (op_go) begin
        clear_pend_r <= op_last;
      end
      case (state_r)
        ST_STREAM: begin
          if (in_acc) begin
            seen_r <= in_row_end ? '0 : n_cur;
            if (in_row_end && (half_w != 2'd0)) begin
              state_r <= ST_FLUSH;
              fd_r    <= half_w - 2'd1;
              n_r     <= n_cur;
            end
          end
        end
        ST_FLUSH: begin
          if (adv) begin
            if (fd_r == 2'd0) begin
              state_r <= ST_STREAM;
            end else begin
              fd_r <= fd_r - 2'd1;
            end
          end
        end
        default: begin
          state_r <= ST_STREAM;
        end
      endcase
    end
  end

  // Feed the cell chain; a pending clear drops the old row
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign tap_in[k] = op_x;
    end else begin : g_body
      assign tap_in[k] = clear_pend_r ? '0 : tap[k-1];
    end

    gsf_tap_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (op_go),
      .capture (adv),
      .tap_in  (tap_in[k]),
      .coeff   (coeff[k]),
      .tap_r   (tap[k]),
      .prod_r  (prod[k])
    );
  end

  // Follow window and product stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
    end else if (adv) begin
      a_r.vld  <= op_go && op_emit;
      a_r.last <= op_last;
      b_r      <= a_r;
    end
  end

  gsf_sum_tree #(
    .MAX_TAPS (MAX_TAPS),
    .PROD_W   (PROD_W),
    .ACC_W    (ACC_W)
  ) u_tree (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .prod    (prod),
    .ctl_in  (b_r),
    .sum     (t_sum),
    .ctl_out (t_ctl)
  );

  // Round half up, then clamp to the sample range
  always_comb begin
    logic signed [ACC_W-1:0] q;
    rnd = t_sum + ROUND_HALF;
    q   = rnd >>> WEIGHT_FRAC_BITS;
    if (q > SAT_HI) begin
      res = SAT_HI[SAMPLE_BITS-1:0];
    end else if (q < SAT_LO) begin
      res = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      res = q[SAMPLE_BITS-1:0];
    end
  end

  assign take = out_valid_r && !out_stall;

  // Output register with one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else if (skid_vld_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
        out_last_r <= skid_last_r;
        skid_vld_r <= 1'b0;
      end
    end else if (t_ctl.vld) begin
      if (!out_valid_r || take) begin
        out_data_r  <= res;
        out_last_r  <= t_ctl.last;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r <= res;
        skid_last_r <= t_ctl.last;
        skid_vld_r  <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_smoothed_height = out_data_r;
  assign out_last_of_row     = out_last_r;

endmodule

@@ rtl/gsf_tap_cell.sv @@
`timescale 1ns / 1ps

module gsf_tap_cell #(
  parameter int SAMPLE_BITS = gsf_pkg::SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   shift,
  input  logic                                   capture,
  input  logic signed [SAMPLE_BITS-1:0]          tap_in,
  input  logic        [gsf_pkg::WEIGHT_BITS-1:0] coeff,
  output logic signed [SAMPLE_BITS-1:0]          tap_r,
  output logic signed [SAMPLE_BITS+gsf_pkg::WEIGHT_BITS-1:0] prod_r
);

  localparam int PROD_W = SAMPLE_BITS + gsf_pkg::WEIGHT_BITS;

  logic signed [PROD_W:0] prod_full;

  // Weight is unsigned: give it a zero sign bit
  assign prod_full = tap_r * $signed({1'b0, coeff});

  // Hold one window sample, pass it to the next cell on every shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (shift) begin
      tap_r <= tap_in;
    end
  end

  // Register the weighted sample
  always_ff @(posedge clk) begin
    if (capture) begin
      prod_r <= prod_full[PROD_W-1:0];
    end
  end

endmodule

@@ rtl/gsf_sum_tree.sv @@
`timescale 1ns / 1ps

module gsf_sum_tree #(
  parameter int MAX_TAPS = gsf_pkg::MAX_TAPS,
  parameter int PROD_W   = gsf_pkg::SAMPLE_BITS + gsf_pkg::WEIGHT_BITS,
  parameter int ACC_W    = PROD_W + 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic signed [PROD_W-1:0] prod [MAX_TAPS],
  input  gsf_pkg::gsf_ctl_t       ctl_in,
  output logic signed [ACC_W-1:0] sum,
  output gsf_pkg::gsf_ctl_t       ctl_out
);

  localparam int LEVELS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int N2     = 1 << LEVELS;
  localparam int HALF_N = N2 / 2;

  logic signed [ACC_W-1:0] leaf   [N2];
  logic signed [ACC_W-1:0] node_r [LEVELS][HALF_N];
  gsf_pkg::gsf_ctl_t       ctl_r  [LEVELS];

  // Sign-extend products, pad the tree with zeros
  for (genvar i = 0; i < N2; i++) begin : g_leaf
    if (i < MAX_TAPS) begin : g_used
      assign leaf[i] = ACC_W'(prod[i]);
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // Add pairs, one registered level after another while en is high
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LEVELS; l++) begin
        for (int i = 0; i < (N2 >> (l + 1)); i++) begin
          if (l == 0) begin
            node_r[l][i] <= leaf[2*i] + leaf[2*i+1];
          end else begin
            node_r[l][i] <= node_r[l-1][2*i] + node_r[l-1][2*i+1];
          end
        end
      end
    end
  end

  // Carry transaction control along the levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        ctl_r[l] <= '0;
      end
    end else if (en) begin
      ctl_r[0] <= ctl_in;
      for (int l = 1; l < LEVELS; l++) begin
        ctl_r[l] <= ctl_r[l-1];
      end
    end
  end

  assign sum     = node_r[LEVELS-1][0];
  assign ctl_out = ctl_r[LEVELS-1];

endmodule

@@ rtl/gsf_checker.sv @@
`timescale 1ns / 1ps

module gsf_checker #(
  parameter int SAMPLE_BITS = gsf_pkg::SAMPLE_BITS
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_smoothed_height,
  input logic                          out_last_of_row
);

  logic free_stall;

  // Input stalled although the output side holds nothing
  assign free_stall = in_stall && !out_valid;

  // Reset leaves no result pending and the input open
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

  // Bound the row flush stall while the output side holds nothing
  a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (free_stall ##1 free_stall ##1 free_stall) |=> !free_stall)
    else $error("input stalled too long with empty output");

  // A stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_smoothed_height)
      && $stable(out_last_of_row))
    else $error("stalled result changed or dropped");

endmodule

bind gaussian_smoothing_fir_zero_pad gsf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_gsf_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_smoothed_height (out_smoothed_height),
  .out_last_of_row     (out_last_of_row)
);

@@ sim/tb_gaussian_smoothing_fir_zero_pad.sv @@
`timescale 1ns / 1ps

module tb_gaussian_smoothing_fir_zero_pad;

  localparam int RANDOM_ITEMS    = 340;
  localparam int PHASE_ITEMS     = 48;
  localparam int DRAIN_CYCLES    = 16;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 100;

  typedef logic signed [gsf_pkg::SAMPLE_BITS-1:0] height_t;

  typedef struct packed {
    height_t height;
    logic    last;
  } smoothed_t;

  typedef enum logic { ROW_SAMPLE, ROW_CFG } row_kind_t;

  // One line of the directed table
  typedef struct packed {
    row_kind_t                         kind;
    logic [gsf_pkg::CFG_IDX_BITS-1:0]  index;
    logic [gsf_pkg::CFG_DATA_BITS-1:0] value;
    height_t                           height;
    logic                              row_end;
    logic                              known;
    smoothed_t                         result;
  } plan_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_we;
  logic [gsf_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [gsf_pkg::CFG_DATA_BITS-1:0] cfg_wdata;
  logic                              in_valid;
  logic                              in_stall;
  height_t                           in_height_sample;
  logic                              in_row_end;
  logic                              out_valid;
  logic                              out_stall;
  height_t                           out_smoothed_height;
  logic                              out_last_of_row;

  // Typed expectation travels with the transaction it belongs to
  logic                     known_chk;
  smoothed_t                known_result;

  int                       idle_pct = 20;
  bit                       hold_off_req = 1'b0;
  int                       mismatches = 0;
  int                       quiet_cycles = 0;

  // Filter image: window newest first, row position counter, registers
  height_t                            window_q [gsf_pkg::MAX_TAPS];
  int                                 row_count;
  logic [gsf_pkg::TAPS_BITS-1:0]      taps_setting;
  logic [gsf_pkg::WEIGHT_BITS-1:0]    weights [gsf_pkg::WEIGHT_REGS];
  smoothed_t                          expected_heights [$];
  smoothed_t                          step_results [$];
  plan_row_t                          plan [$];

  gaussian_smoothing_fir_zero_pad DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_height_sample    (in_height_sample),
    .in_row_end          (in_row_end),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_smoothed_height (out_smoothed_height),
    .out_last_of_row     (out_last_of_row)
  );

  always #5 clk = ~clk;

  // Weighted sum centred d places back from the newest sample, round half up, saturate
  function automatic height_t weighted_sum_at(int d, int h);
    longint acc;
    longint q;
    longint hi;
    int     k;
    int     t;
    acc = 0;
    for (t = 0; t <= 2 * h; t++) begin
      k = d + h - t;
      if (k >= 0 && k < gsf_pkg::MAX_TAPS)
        acc += longint'(window_q[k]) * longint'(weights[t]);
    end
    acc += longint'(1) << (gsf_pkg::WEIGHT_FRAC_BITS - 1);
    q = acc >>> gsf_pkg::WEIGHT_FRAC_BITS;
    hi = (longint'(1) << (gsf_pkg::SAMPLE_BITS - 1)) - 1;
    if (q > hi) q = hi;
    if (q < -hi - 1) q = -hi - 1;
    return height_t'(q);
  endfunction

  // Advance the filter image by one sample and collect the results it releases
  function automatic void filter_step(height_t sample, logic row_end);
    int h;
    int n;
    int start;
    h = int'(taps_setting) / 2;
    for (int i = gsf_pkg::MAX_TAPS - 1; i > 0; i--) window_q[i] = window_q[i - 1];
    window_q[0] = sample;
    if (row_count < gsf_pkg::MAX_TAPS) row_count++;
    n = row_count;
    step_results.delete();
    if (row_end) begin
      // flush every pending position, the last one marked
      start = (n - 1 < h) ? n - 1 : h;
      for (int d = start; d >= 0; d--)
        step_results.push_back('{weighted_sum_at(d, h), d == 0});
      foreach (window_q[i]) window_q[i] = '0;
      row_count = 0;
    end else if (n > h) begin
      step_results.push_back('{weighted_sum_at(h, h), 1'b0});
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic plan_row_t cfg_row(logic [gsf_pkg::CFG_IDX_BITS-1:0] index,
                                        logic [gsf_pkg::CFG_DATA_BITS-1:0] value);
    return '{ROW_CFG, index, value, '0, 1'b0, 1'b0, '0};
  endfunction

  function automatic plan_row_t sample_row(height_t height, logic row_end);
    return '{ROW_SAMPLE, '0, '0, height, row_end, 1'b0, '0};
  endfunction

  function automatic plan_row_t known_row(height_t height, logic row_end,
                                          height_t want_height, logic want_last);
    return '{ROW_SAMPLE, '0, '0, height, row_end, 1'b1, '{want_height, want_last}};
  endfunction

  // Offer one sample, with an optional idle burst ahead of it; return once accepted
  task automatic offer_sample(input height_t sample, input logic row_end,
                              input logic known, input smoothed_t result);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_height_sample <= sample;
    in_row_end       <= row_end;
    known_chk        <= known;
    known_result     <= result;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every expected result is out and the pipe is empty
  task automatic settle_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_heights.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [gsf_pkg::CFG_IDX_BITS-1:0] index,
                                input logic [gsf_pkg::CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    if (index == gsf_pkg::CFG_TAPS_USED) taps_setting = value[gsf_pkg::TAPS_BITS-1:0];
    else weights[index - gsf_pkg::CFG_TAP_WEIGHT_0] = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Predict on each accepted sample, check each accepted result
  always @(posedge clk) begin : scoreboard
    smoothed_t want;
    if (rst_n && in_valid && !in_stall) begin
      filter_step(in_height_sample, in_row_end);
      if (known_chk) expected_heights.push_back(known_result);
      else foreach (step_results[i]) expected_heights.push_back(step_results[i]);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_heights.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", out_smoothed_height));
      end else begin
        want = expected_heights.pop_front();
        if (out_smoothed_height !== want.height)
          report_mismatch($sformatf("smoothed_height %0d, expected %0d",
                                    out_smoothed_height, want.height));
        if (out_last_of_row !== want.last)
          report_mismatch($sformatf("last_of_row %b, expected %b",
                                    out_last_of_row, want.last));
      end
    end
  end

  // End the run if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[gaussian_smoothing_fir_zero_pad] ERROR");
      $finish;
    end
  end

  // Receiver: short random stalls, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    bit      was_streaming;
    int      random_items;
    int      phase;
    int      phase_items;
    int      row_len;
    int      taps;
    height_t sample;
    logic [gsf_pkg::CFG_DATA_BITS-1:0] weight;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    in_height_sample <= '0;
    in_row_end       <= 1'b0;
    known_chk        <= 1'b0;
    known_result     <= '0;

    // Filter image after reset: identity kernel, empty window
    foreach (window_q[i]) window_q[i] = '0;
    foreach (weights[i]) weights[i] = '0;
    weights[0]   = gsf_pkg::WEIGHT_ONE;
    taps_setting = gsf_pkg::TAPS_RESET;
    row_count    = 0;

    // Identity after reset: each sample comes straight back
    plan.push_back(known_row(16'sh7FFF, 1'b0, 16'sh7FFF, 1'b0));
    plan.push_back(known_row(16'sh8000, 1'b0, 16'sh8000, 1'b0));
    plan.push_back(known_row(16'sh0000, 1'b0, 16'sh0000, 1'b0));
    plan.push_back(known_row(-16'sd1,   1'b1, -16'sd1,   1'b1));
    plan.push_back(known_row(16'sd1,    1'b1, 16'sd1,    1'b1));
    // Seven taps, every weight at its 16-bit top: saturation on a long row
    plan.push_back(cfg_row(gsf_pkg::CFG_TAPS_USED, 16'd7));
    plan.push_back(cfg_row(gsf_pkg::CFG_TAP_WEIGHT_0,        16'hFFFF));
    plan.push_back(cfg_row(gsf_pkg::CFG_TAP_WEIGHT_0 + 3'd1, 16'hFFFF));
    plan.push_back(cfg_row(gsf_pkg::CFG_TAP_WEIGHT_0 + 3'd2, 16'hFFFF));
    plan.push_back(cfg_row(gsf_pkg::CFG_TAP_WEIGHT_0 + 3'd3, 16'hFFFF));
    plan.push_back(cfg_row(gsf_pkg::CFG_TAP_WEIGHT_0 + 3'd4, 16'hFFFF));
    plan.push_back(cfg_row(gsf_pkg::CFG_TAP_WEIGHT_0 + 3'd5, 16'hFFFF));
    plan.push_back(cfg_row(gsf_pkg::CFG_TAP_WEIGHT_0 + 3'd6, 16'hFFFF));
    plan.push_back(sample_row(16'sd20000,  1'b0));
    plan.push_back(sample_row(16'sd20000,  1'b0));
    plan.push_back(sample_row(16'sd20000,  1'b0));
    plan.push_back(sample_row(16'sh8000,   1'b0));
    plan.push_back(sample_row(16'sh8000,   1'b0));
    plan.push_back(sample_row(16'sh8000,   1'b0));
    plan.push_back(sample_row(16'sd12345,  1'b0));
    plan.push_back(sample_row(-16'sd20000, 1'b1));
    // Zero tap count acts as one; half weight exposes round half up
    plan.push_back(cfg_row(gsf_pkg::CFG_TAPS_USED, 16'd0));
    plan.push_back(cfg_row(gsf_pkg::CFG_TAP_WEIGHT_0, 16'd16384));
    plan.push_back(sample_row(16'sd1,  1'b0));
    plan.push_back(sample_row(-16'sd1, 1'b0));
    plan.push_back(sample_row(16'sd3,  1'b0));
    plan.push_back(sample_row(-16'sd3, 1'b1));
    // Two taps act as three; a one-sample row ends before the half width
    plan.push_back(cfg_row(gsf_pkg::CFG_TAPS_USED, 16'd2));
    plan.push_back(cfg_row(gsf_pkg::CFG_TAP_WEIGHT_0,        16'd8192));
    plan.push_back(cfg_row(gsf_pkg::CFG_TAP_WEIGHT_0 + 3'd1, 16'd16384));
    plan.push_back(cfg_row(gsf_pkg::CFG_TAP_WEIGHT_0 + 3'd2, 16'd8192));
    plan.push_back(sample_row(16'sh8000, 1'b1));
    plan.push_back(sample_row(16'sh7FFF, 1'b0));
    plan.push_back(sample_row(16'sh7FFF, 1'b1));
    // Six taps act as seven; rows shorter than the kernel
    plan.push_back(cfg_row(gsf_pkg::CFG_TAPS_USED, 16'd6));
    plan.push_back(sample_row(16'sd100,  1'b0));
    plan.push_back(sample_row(-16'sd100, 1'b1));
    plan.push_back(sample_row(16'sd256,  1'b0));
    plan.push_back(sample_row(16'sd512,  1'b0));
    plan.push_back(sample_row(-16'sd768, 1'b1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    was_streaming = 1'b0;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        if (was_streaming) settle_block();
        was_streaming = 1'b0;
        write_register(plan[r].index, plan[r].value);
      end else begin
        offer_sample(plan[r].height, plan[r].row_end, plan[r].known, plan[r].result);
        was_streaming = 1'b1;
      end
    end
    settle_block();

    // Random phases: fresh settings, then whole rows of random heights
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= RANDOM_ITEMS - 2 * PHASE_ITEMS) idle_pct = 0;
      else idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;

      case (phase)
        0:       taps = 7;
        1:       taps = 1;
        default: taps = $urandom_range(0, 7);
      endcase
      write_register(gsf_pkg::CFG_TAPS_USED, gsf_pkg::CFG_DATA_BITS'(taps));
      for (int w = 0; w < gsf_pkg::WEIGHT_REGS; w++) begin
        case ($urandom_range(0, 3))
          0:       weight = gsf_pkg::CFG_DATA_BITS'($urandom_range(0, 8192));
          1:       weight = gsf_pkg::CFG_DATA_BITS'($urandom_range(0, 32768));
          2:       weight = gsf_pkg::CFG_DATA_BITS'($urandom_range(0, 16'hFFFF));
          default: weight = $urandom_range(0, 1) ? gsf_pkg::WEIGHT_ONE
                                                 : ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        endcase
        write_register(gsf_pkg::CFG_TAP_WEIGHT_0 + gsf_pkg::CFG_IDX_BITS'(w), weight);
      end

      // Back-pressure the block until it stalls its input
      if (phase == 2) hold_off_req = 1'b1;

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        row_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
        for (int s = 0; s < row_len; s++) begin
          // Let the output run dry in the middle of a row once
          if (phase == 3 && phase_items == 5) settle_block();
          case ($urandom_range(0, 5))
            0: begin
              case ($urandom_range(0, 3))
                0:       sample = 16'sh8000;
                1:       sample = 16'sh7FFF;
                2:       sample = 16'sh0000;
                default: sample = -16'sd1;
              endcase
            end
            1:       sample = height_t'($urandom_range(0, 1023) - 512);
            default: sample = height_t'($urandom_range(0, 16'hFFFF));
          endcase
          offer_sample(sample, s == row_len - 1, 1'b0, '0);
          phase_items++;
        end
      end
      random_items += phase_items;
      settle_block();
      phase++;
    end

    if (mismatches == 0) begin
      $display("[gaussian_smoothing_fir_zero_pad] OK");
    end else begin
      $display("[gaussian_smoothing_fir_zero_pad] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gsf_pkg.sv
rtl/gsf_tap_cell.sv
rtl/gsf_sum_tree.sv
rtl/gaussian_smoothing_fir_zero_pad.sv
rtl/gsf_checker.sv
sim/tb_gaussian_smoothing_fir_zero_pad.sv
